// ----- sv/cmap_pkg.sv -----
package cmap_pkg;

    // Width of the gain register and its value after reset.
    localparam int SCALE_BITS = 24;
    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 24'd4097;

    // A product at or above 2^27 is a position of 8.0 or more.
    localparam int OVER_BIT = SCALE_BITS + 3;

    // Palette geometry.
    localparam int PALETTE_SIZE = 9;
    localparam int CHANNELS     = 3;
    localparam int COLOR_BITS   = 8;
    localparam int SEL_BITS     = 4;
    localparam int IDX_BITS     = 3;

    localparam logic [SEL_BITS-1:0] SEL_FIRST = 4'd0;
    localparam logic [SEL_BITS-1:0] SEL_LAST  = 4'd8;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam logic [COLOR_BITS-1:0] PALETTE [PALETTE_SIZE][CHANNELS] = '{
        '{8'd0,   8'd0,   8'd0},
        '{8'd38,  8'd38,  8'd128},
        '{8'd76,  8'd38,  8'd191},
        '{8'd153, 8'd51,  8'd128},
        '{8'd255, 8'd64,  8'd38},
        '{8'd230, 8'd128, 8'd0},
        '{8'd230, 8'd191, 8'd26},
        '{8'd230, 8'd230, 8'd128},
        '{8'd255, 8'd255, 8'd255}
    };

    // Status carried alongside the position from the multiply stage.
    typedef struct packed {
        logic neg;
        logic over;
    } cmap_flags_t;

endpackage

// ----- sv/cmap_mul.sv -----
module cmap_mul #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [SAMPLE_BITS-1:0]        sample,
    input  logic [cmap_pkg::SCALE_BITS-1:0]      scale,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output cmap_pkg::cmap_flags_t                out_flags,
    output logic [FRAC_BITS+2:0]                 out_pos
);

    localparam int MAG_BITS  = SAMPLE_BITS - 1;
    localparam int PROD_BITS = MAG_BITS + cmap_pkg::SCALE_BITS;
    localparam int POS_LSB   = cmap_pkg::SCALE_BITS - FRAC_BITS;

    // Stage one: registered sample split into sign and magnitude.
    logic                 v1_reg;
    logic                 neg1_reg;
    logic [MAG_BITS-1:0]  mag1_reg;

    // Stage two: product reduced to flags and position.
    logic                  v2_reg;
    cmap_pkg::cmap_flags_t flags2_reg;
    cmap_pkg::cmap_flags_t flags2_next;
    logic [FRAC_BITS+2:0]  pos2_reg;
    logic [FRAC_BITS+2:0]  pos2_next;

    logic                 ready1;
    logic                 ready2;
    logic [PROD_BITS-1:0] prod;

    assign ready2   = !v2_reg || out_ready;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    assign prod = {{cmap_pkg::SCALE_BITS{1'b0}}, mag1_reg}
                * {{MAG_BITS{1'b0}}, scale};

    always_comb begin
        flags2_next.neg  = neg1_reg;
        flags2_next.over = !neg1_reg && (|prod[PROD_BITS-1:cmap_pkg::OVER_BIT]);
        pos2_next        = prod[cmap_pkg::OVER_BIT-1:POS_LSB];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= in_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && in_valid) begin
            neg1_reg <= sample[SAMPLE_BITS-1];
            mag1_reg <= sample[MAG_BITS-1:0];
        end
        if (ready2 && v1_reg) begin
            flags2_reg <= flags2_next;
            pos2_reg   <= pos2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_flags = flags2_reg;
    assign out_pos   = pos2_reg;

`ifndef ASSERT_OFF
    // A negative sample never reports overflow as well.
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> !(flags2_reg.neg && flags2_reg.over))
        else $error("negative and overflow flags set together");

    // A stalled second stage keeps its item.
    a_stage2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !out_ready) |=> (v2_reg && $stable(pos2_reg) && $stable(flags2_reg)))
        else $error("second stage item lost under stall");
`endif

endmodule

// ----- sv/cmap_blend.sv -----
module cmap_blend #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  cmap_pkg::cmap_flags_t                in_flags,
    input  logic [FRAC_BITS+2:0]                 in_pos,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [cmap_pkg::COLOR_BITS-1:0]      out_red,
    output logic [cmap_pkg::COLOR_BITS-1:0]      out_green,
    output logic [cmap_pkg::COLOR_BITS-1:0]      out_blue,
    output logic                                 out_clipped
);

    localparam int ACC_BITS = FRAC_BITS + 10;

    logic [cmap_pkg::IDX_BITS-1:0] idx;
    logic [FRAC_BITS-1:0]          frac;
    logic [cmap_pkg::SEL_BITS-1:0] lo_sel;
    logic [cmap_pkg::SEL_BITS-1:0] hi_sel;
    logic [cmap_pkg::COLOR_BITS-1:0] chan [cmap_pkg::CHANNELS];
    logic [cmap_pkg::COLOR_BITS-1:0] color_next [cmap_pkg::CHANNELS];

    logic                            valid_reg;
    logic [cmap_pkg::COLOR_BITS-1:0] red_reg;
    logic [cmap_pkg::COLOR_BITS-1:0] green_reg;
    logic [cmap_pkg::COLOR_BITS-1:0] blue_reg;
    logic                            clipped_reg;
    logic                            clipped_next;

    assign idx    = in_pos[FRAC_BITS+2:FRAC_BITS];
    assign frac   = in_pos[FRAC_BITS-1:0];
    assign lo_sel = {1'b0, idx};
    assign hi_sel = lo_sel + 4'd1;

    for (genvar ch = 0; ch < cmap_pkg::CHANNELS; ch++) begin : g_chan
        logic [cmap_pkg::COLOR_BITS-1:0] lo;
        logic [cmap_pkg::COLOR_BITS-1:0] hi;
        logic signed [ACC_BITS-1:0]      diff;
        logic signed [ACC_BITS-1:0]      weight;
        logic signed [ACC_BITS-1:0]      acc;

        assign lo     = cmap_pkg::PALETTE[lo_sel][ch];
        assign hi     = cmap_pkg::PALETTE[hi_sel][ch];
        assign diff   = $signed({{(ACC_BITS-cmap_pkg::COLOR_BITS){1'b0}}, hi})
                      - $signed({{(ACC_BITS-cmap_pkg::COLOR_BITS){1'b0}}, lo});
        assign weight = $signed({{(ACC_BITS-FRAC_BITS){1'b0}}, frac});
        // The sum never goes negative since the fraction is below one.
        assign acc    = $signed({2'b00, lo, {FRAC_BITS{1'b0}}}) + diff * weight;
        assign chan[ch] = acc[FRAC_BITS+cmap_pkg::COLOR_BITS-1:FRAC_BITS];

        always_comb begin
            if (in_flags.neg) begin
                color_next[ch] = cmap_pkg::PALETTE[cmap_pkg::SEL_FIRST][ch];
            end else if (in_flags.over) begin
                color_next[ch] = cmap_pkg::PALETTE[cmap_pkg::SEL_LAST][ch];
            end else begin
                color_next[ch] = chan[ch];
            end
        end
    end

    assign clipped_next = in_flags.neg || in_flags.over;
    assign in_ready     = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            red_reg     <= color_next[cmap_pkg::CH_RED];
            green_reg   <= color_next[cmap_pkg::CH_GREEN];
            blue_reg    <= color_next[cmap_pkg::CH_BLUE];
            clipped_reg <= clipped_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_red     = red_reg;
    assign out_green   = green_reg;
    assign out_blue    = blue_reg;
    assign out_clipped = clipped_reg;

`ifndef ASSERT_OFF
    // An item taken from the multiply stage shows up at the output next cycle.
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> valid_reg)
        else $error("accepted item did not reach the output register");
`endif

endmodule

// ----- sv/scalar_to_rgb_colormap_core.sv -----
// Channel   | Ports                                        | Direction
// ----------+----------------------------------------------+----------
// input     | s_valid, s_ready, s_sample                   | in
// result    | m_valid, m_ready, m_red, m_green, m_blue,    | out
//           | m_clipped                                    |
// config    | cfg_we, cfg_wdata (gain register)            | in
//
// One item enters per clock unless a full pipeline is stalled by m_ready. An item
// is loaded into the input register at the edge that accepts it, then moves on
// to the multiply register and then the output register, from which it is
// offered on the result channel.
// Reset is synchronous and active low; it empties the pipeline and loads
// the gain register with its default of 4097.
// Each stage holds its item while the stage after it is full and stalled,
// so a bubble anywhere lets a new item in even while the output waits.
module scalar_to_rgb_colormap_core #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_we,
    input  logic [cmap_pkg::SCALE_BITS-1:0]      cfg_wdata,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [SAMPLE_BITS-1:0]        s_sample,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [cmap_pkg::COLOR_BITS-1:0]      m_red,
    output logic [cmap_pkg::COLOR_BITS-1:0]      m_green,
    output logic [cmap_pkg::COLOR_BITS-1:0]      m_blue,
    output logic                                 m_clipped
);

    // The gain is 2^27 divided by the full-scale sample, so the product of
    // sample and gain crosses 2^27 exactly at palette position 8.0.
    logic [cmap_pkg::SCALE_BITS-1:0] scale_reg;

    // Link between the multiply pipeline and the blend stage.
    logic                  mul_valid;
    logic                  mul_ready;
    cmap_pkg::cmap_flags_t mul_flags;
    logic [FRAC_BITS+2:0]  mul_pos;

    // The gain is to be rewritten only while the pipeline is empty; the user must
    // ensure it (the block does not), so no item ever sees two different values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= cmap_pkg::SCALE_RESET;
        end else if (cfg_we) begin
            scale_reg <= cfg_wdata;
        end
    end

    // First two stages: capture the sample, then form the fixed-point
    // position (three integer bits, FRAC_BITS fraction bits) together with
    // the negative and overflow flags.
    cmap_mul #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .sample    (s_sample),
        .scale     (scale_reg),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_flags (mul_flags),
        .out_pos   (mul_pos)
    );

    // Last stage: palette lookup of the two neighboring colors, linear blend
    // by the fraction, and substitution of the end colors for clipped items.
    cmap_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (mul_valid),
        .in_ready    (mul_ready),
        .in_flags    (mul_flags),
        .in_pos      (mul_pos),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_red     (m_red),
        .out_green   (m_green),
        .out_blue    (m_blue),
        .out_clipped (m_clipped)
    );

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SMP_W     = 16;
    localparam int FRAC      = 8;
    // A position at or past this value saturates to the last palette entry.
    localparam int POS_LIMIT = (cmap_pkg::PALETTE_SIZE - 1) << FRAC;
    localparam int PIPE_LAT  = 3;
    localparam int ITEMS_PER_PHASE = 225;

    // One mapped pixel as it leaves the result channel.
    typedef struct packed {
        logic [cmap_pkg::COLOR_BITS-1:0] red;
        logic [cmap_pkg::COLOR_BITS-1:0] green;
        logic [cmap_pkg::COLOR_BITS-1:0] blue;
        logic                            clipped;
    } pixel_t;

    // Our own copy of the color ramp, so a wrong table in the design is caught.
    localparam logic [7:0] SWATCH [cmap_pkg::PALETTE_SIZE][cmap_pkg::CHANNELS] = '{
        '{8'd0,   8'd0,   8'd0},
        '{8'd38,  8'd38,  8'd128},
        '{8'd76,  8'd38,  8'd191},
        '{8'd153, 8'd51,  8'd128},
        '{8'd255, 8'd64,  8'd38},
        '{8'd230, 8'd128, 8'd0},
        '{8'd230, 8'd191, 8'd26},
        '{8'd230, 8'd230, 8'd128},
        '{8'd255, 8'd255, 8'd255}
    };

    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic                              cfg_we    = 1'b0;
    logic [cmap_pkg::SCALE_BITS-1:0]   cfg_wdata = '0;
    logic                              s_valid   = 1'b0;
    logic                              s_ready;
    logic signed [SMP_W-1:0]           s_sample  = '0;
    logic                              m_valid;
    logic                              m_ready   = 1'b0;
    logic [cmap_pkg::COLOR_BITS-1:0]   m_red;
    logic [cmap_pkg::COLOR_BITS-1:0]   m_green;
    logic [cmap_pkg::COLOR_BITS-1:0]   m_blue;
    logic                              m_clipped;

    // Gain the design holds right now; it only changes while nothing is in flight.
    logic [cmap_pkg::SCALE_BITS-1:0]   gain_now = cmap_pkg::SCALE_RESET;
    // When set, neither side inserts idle cycles.
    bit                                steady   = 1'b0;

    logic signed [SMP_W-1:0] samples_to_send [$];
    pixel_t                  pixels_due [$];

    int samples_sent   = 0;
    int pixels_checked = 0;
    int clipped_seen   = 0;
    int gain_settings  = 1;
    int failures       = 0;

    scalar_to_rgb_colormap_core #(
        .SAMPLE_BITS (SMP_W),
        .FRAC_BITS   (FRAC)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_red     (m_red),
        .m_green   (m_green),
        .m_blue    (m_blue),
        .m_clipped (m_clipped)
    );

    always #5 aclk = ~aclk;

    // Works out the pixel for one sample under the given gain. The position
    // is the product shifted down to Q3.8; its integer part picks a pair of
    // neighboring colors and the fraction blends between them.
    function automatic pixel_t map_sample_to_pixel(logic signed [SMP_W-1:0] smp,
                                                   logic [cmap_pkg::SCALE_BITS-1:0] gain);
        pixel_t      px;
        logic [39:0] product;
        logic [39:0] pos;
        int          seg;
        int          frac;
        int          lo;
        int          hi;
        int          acc;
        int          blended [cmap_pkg::CHANNELS];

        // Negative samples fall below the ramp: first color, flagged.
        if (smp[SMP_W-1]) begin
            px.red     = SWATCH[0][cmap_pkg::CH_RED];
            px.green   = SWATCH[0][cmap_pkg::CH_GREEN];
            px.blue    = SWATCH[0][cmap_pkg::CH_BLUE];
            px.clipped = 1'b1;
            return px;
        end

        product = {25'd0, smp[SMP_W-2:0]} * {16'd0, gain};
        pos     = product >> (cmap_pkg::SCALE_BITS - FRAC);

        // Full scale or beyond saturates to white, also flagged.
        if (pos >= POS_LIMIT) begin
            px.red     = SWATCH[cmap_pkg::PALETTE_SIZE-1][cmap_pkg::CH_RED];
            px.green   = SWATCH[cmap_pkg::PALETTE_SIZE-1][cmap_pkg::CH_GREEN];
            px.blue    = SWATCH[cmap_pkg::PALETTE_SIZE-1][cmap_pkg::CH_BLUE];
            px.clipped = 1'b1;
            return px;
        end

        seg  = int'(pos >> FRAC);
        frac = int'(pos[FRAC-1:0]);
        for (int ch = 0; ch < cmap_pkg::CHANNELS; ch++) begin
            lo  = int'(SWATCH[seg][ch]);
            hi  = int'(SWATCH[seg+1][ch]);
            acc = lo * (1 << FRAC) + (hi - lo) * frac;
            if (acc < 0) begin
                acc = 0;
            end
            blended[ch] = (acc >> FRAC) & 255;
        end
        px.red     = blended[cmap_pkg::CH_RED][7:0];
        px.green   = blended[cmap_pkg::CH_GREEN][7:0];
        px.blue    = blended[cmap_pkg::CH_BLUE][7:0];
        px.clipped = 1'b0;
        return px;
    endfunction

    // Sender side. An item leaves when valid and ready meet at a clock edge;
    // the expected pixel is computed right then, under the gain in force.
    // A new item is presented only once the previous one is gone, and with a
    // chance of 15 in 100 the sender holds back unless the run is in a steady
    // stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_sample <= '0;
        end else begin
            if (s_valid && s_ready) begin
                pixels_due.push_back(map_sample_to_pixel(s_sample, gain_now));
                samples_sent++;
            end
            if (!s_valid || s_ready) begin
                if (samples_to_send.size() > 0 && (steady || $urandom_range(99) >= 15)) begin
                    s_valid  <= 1'b1;
                    s_sample <= samples_to_send.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver side. Every accepted pixel is compared against the oldest
    // outstanding expectation; ready drops at random to stall the pipeline.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pixels_due.size() == 0) begin
                    $error("Pixel received with no sample outstanding");
                    failures++;
                end else begin
                    pixel_t want;
                    want = pixels_due.pop_front();
                    if (m_red !== want.red) begin
                        $error("red: expected %0d, got %0d", want.red, m_red);
                        failures++;
                    end
                    if (m_green !== want.green) begin
                        $error("green: expected %0d, got %0d", want.green, m_green);
                        failures++;
                    end
                    if (m_blue !== want.blue) begin
                        $error("blue: expected %0d, got %0d", want.blue, m_blue);
                        failures++;
                    end
                    if (m_clipped !== want.clipped) begin
                        $error("clipped: expected %0d, got %0d", want.clipped, m_clipped);
                        failures++;
                    end
                    if (want.clipped) begin
                        clipped_seen++;
                    end
                end
                pixels_checked++;
            end
            m_ready <= steady || ($urandom_range(99) >= 15);
        end
    end

    // Blocks until every queued sample has gone in and every pixel has come
    // out, so the pipeline is empty.
    task automatic wait_drained();
        while (samples_to_send.size() != 0 || s_valid || pixels_due.size() != 0) begin
            @(posedge aclk);
        end
        @(posedge aclk);
    endtask

    // Writes the gain register. Only called with the pipeline empty.
    task automatic load_gain(logic [cmap_pkg::SCALE_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        gain_now  = value;
        gain_settings++;
        @(posedge aclk);
    endtask

    // Queues random samples. Of every hundred picks, 35 land on the useful part of
    // the ramp for the current gain, 15 sit right at the saturation point, 15 are
    // negative and the rest are anywhere in the 16-bit range.
    task automatic queue_random(int count);
        longint full_scale;
        longint smp;
        int     pick;

        if (gain_now == 0) begin
            full_scale = 32767;
        end else begin
            full_scale = (longint'(1) << 27) / longint'(gain_now);
        end
        if (full_scale > 32767) begin
            full_scale = 32767;
        end
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                smp = longint'($urandom_range(int'(full_scale), 0));
            end else if (pick < 50) begin
                smp = full_scale + longint'($urandom_range(6)) - 3;
                if (smp < 0) begin
                    smp = 0;
                end
                if (smp > 32767) begin
                    smp = 32767;
                end
            end else if (pick < 65) begin
                smp = -longint'($urandom_range(32768, 1));
            end else begin
                smp = longint'($signed(16'($urandom)));
            end
            samples_to_send.push_back(SMP_W'(smp));
        end
    endtask

    initial begin
        // Directed samples under the gain left by reset: the ends of the
        // sample range, the smallest magnitudes either side of zero, one
        // sample near each palette entry, and the pair that straddles the
        // saturation point (32760 stays on the ramp, 32761 clips).
        samples_to_send.push_back(16'sd0);
        samples_to_send.push_back(16'sd1);
        samples_to_send.push_back(-16'sd1);
        samples_to_send.push_back(16'sh7FFF);
        samples_to_send.push_back(16'sh8000);
        for (int k = 1; k < cmap_pkg::PALETTE_SIZE; k++) begin
            samples_to_send.push_back(SMP_W'(k * 4096 - 1));
        end
        samples_to_send.push_back(16'sd32760);
        samples_to_send.push_back(16'sd32761);
        samples_to_send.push_back(16'sh5555);
        samples_to_send.push_back(16'sh2AAA);
        samples_to_send.push_back(16'sd2048);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Each phase runs a batch of samples, then the sender waits until
        // every expected pixel has come back before the gain changes.
        queue_random(ITEMS_PER_PHASE);
        wait_drained();

        // Zero gain: everything that is not negative maps to the first color.
        load_gain('0);
        queue_random(ITEMS_PER_PHASE);
        wait_drained();

        // Smallest nonzero gain keeps the position at zero.
        load_gain(24'd1);
        queue_random(ITEMS_PER_PHASE);
        wait_drained();

        // Largest gain: almost every positive sample saturates.
        load_gain({cmap_pkg::SCALE_BITS{1'b1}});
        queue_random(ITEMS_PER_PHASE);
        wait_drained();

        // Full scale lies just past the top of the sample range, so no positive sample clips.
        load_gain(24'd4096);
        queue_random(ITEMS_PER_PHASE);
        wait_drained();

        // Full scale at a sample of about one thousand.
        load_gain(24'd134217);
        queue_random(ITEMS_PER_PHASE);
        wait_drained();

        load_gain(24'($urandom_range(24'hFFFFFF, 0)));
        queue_random(ITEMS_PER_PHASE);
        wait_drained();

        load_gain(24'($urandom_range(200000, 4000)));
        queue_random(ITEMS_PER_PHASE);
        wait_drained();

        // Back to the default gain, with both sides running flat out.
        load_gain(cmap_pkg::SCALE_RESET);
        steady = 1'b1;
        queue_random(ITEMS_PER_PHASE);
        wait_drained();
        steady = 1'b0;

        // Leave room for any stray pixel the design might still emit.
        repeat (PIPE_LAT + 8) @(posedge aclk);

        $display("Mapped %0d samples to %0d pixels across %0d gain settings.",
                 samples_sent, pixels_checked, gain_settings);
        $display("Pixels flagged as clipped: %0d, mismatches found: %0d.",
                 clipped_seen, failures);
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Timed out waiting for the run to finish.");
        $display("Simulation FAILED");
        $finish;
    end

endmodule
